>>> rtl/gpx_pkg.sv
// ----------------------------------------------------------------------------
// gpx_pkg
// Types, register map and helpers for the 16-pin port expander register file.
// ----------------------------------------------------------------------------
`default_nettype none

package gpx_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAMPLE = 2'd2
  } gpx_cmd_e;

  // Register map, word index (byte address >> 1); A at even, B at odd byte
  localparam logic [3:0] WADR_DIR   = 4'h0;  // 0x00/0x01
  localparam logic [3:0] WADR_INTEN = 4'h2;  // 0x04/0x05
  localparam logic [3:0] WADR_DEFV  = 4'h3;  // 0x06/0x07
  localparam logic [3:0] WADR_MODE  = 4'h4;  // 0x08/0x09
  localparam logic [3:0] WADR_CTRL  = 4'h5;  // 0x0A/0x0B
  localparam logic [3:0] WADR_PULL  = 4'h6;  // 0x0C/0x0D
  localparam logic [3:0] WADR_FLAG  = 4'h7;  // 0x0E/0x0F
  localparam logic [3:0] WADR_CAPT  = 4'h8;  // 0x10/0x11
  localparam logic [3:0] WADR_PORT  = 4'h9;  // 0x12/0x13

  // Control byte bits
  localparam int unsigned CTRL_MIRROR_BIT = 6;  // 0x40
  localparam int unsigned CTRL_INTPOL_BIT = 1;  // 0x02

  localparam logic [15:0] DIR_RESET = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] pin_levels;
  } gpx_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        int_a_line;
    logic        int_b_line;
    logic [15:0] drive_level;
    logic [15:0] drive_enable;
    logic [15:0] pullup_enable;
  } gpx_out_t;

  // Replace one byte of a 16-bit port pair
  function automatic logic [15:0] put_byte(logic [15:0] w, logic hi, logic [7:0] b);
    put_byte = hi ? {b, w[7:0]} : {w[15:8], b};
  endfunction

  // Pick one byte of a 16-bit port pair
  function automatic logic [7:0] get_byte(logic [15:0] w, logic hi);
    get_byte = hi ? w[15:8] : w[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/gpio_expander_register_file.sv
// ----------------------------------------------------------------------------
// gpio_expander_register_file
// Register file of a 16-pin port expander with interrupt on change.
// ----------------------------------------------------------------------------
// Each transfer is a byte register write, a byte register read or a new
// sample of the pin levels; every transfer yields one result holding the read
// byte (zero for non-reads), both interrupt lines and the pin drive, enable
// and pull-up words as they stand after that item. The block is a two-stage
// pipeline: an input register, then the register-file logic that updates the
// state and loads the result register. Throughput is one item per clock;
// the input stalls only while the result register holds a result that the
// receiver has not taken. Each item passes the input register, then the
// result register; a stall can hold it in the input register.
// Reading the capture or GPIO register of a port clears that port's flags.
`default_nettype none

module gpio_expander_register_file (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire gpx_pkg::gpx_in_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output gpx_pkg::gpx_out_t   out_data_o
);
  import gpx_pkg::*;

  // Pipeline control
  logic     s1_valid_q;
  gpx_in_t  s1_q;
  logic     out_valid_q;
  gpx_out_t out_q;
  logic     advance;
  logic     fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  // State
  logic [15:0] dir_q, dir_d;
  logic [15:0] pull_q, pull_d;
  logic [15:0] latch_q, latch_d;
  logic [15:0] inten_q, inten_d;
  logic [15:0] defv_q, defv_d;
  logic [15:0] mode_q, mode_d;
  logic [15:0] flag_q, flag_d;
  logic [15:0] capt_q, capt_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [15:0] last_q, last_d;

  logic [3:0]  wadr;
  logic        hi;
  logic [7:0]  rd_byte;
  logic [15:0] ref_lv;
  logic [15:0] hit;
  logic [15:0] clr_mask;
  logic        act_a, act_b, line_a, line_b;
  gpx_out_t    res;

  assign wadr     = s1_q.reg_addr[4:1];
  assign hi       = s1_q.reg_addr[0];
  assign clr_mask = hi ? 16'hFF00 : 16'h00FF;
  assign ref_lv   = (mode_q & defv_q) | (~mode_q & last_q);
  assign hit      = (s1_q.pin_levels ^ ref_lv) & inten_q;

  // Register file update for the item in stage 1
  always_comb begin
    dir_d   = dir_q;
    pull_d  = pull_q;
    latch_d = latch_q;
    inten_d = inten_q;
    defv_d  = defv_q;
    mode_d  = mode_q;
    flag_d  = flag_q;
    capt_d  = capt_q;
    ctrl_d  = ctrl_q;
    last_d  = last_q;
    rd_byte = 8'h00;
    case (s1_q.command)
      CMD_WRITE: begin
        unique case (wadr)
          WADR_DIR:   dir_d   = put_byte(dir_q, hi, s1_q.write_data);
          WADR_INTEN: inten_d = put_byte(inten_q, hi, s1_q.write_data);
          WADR_DEFV:  defv_d  = put_byte(defv_q, hi, s1_q.write_data);
          WADR_MODE:  mode_d  = put_byte(mode_q, hi, s1_q.write_data);
          WADR_CTRL:  ctrl_d  = s1_q.write_data;
          WADR_PULL:  pull_d  = put_byte(pull_q, hi, s1_q.write_data);
          WADR_PORT:  latch_d = put_byte(latch_q, hi, s1_q.write_data);
          default:    ;  // read-only or unmapped
        endcase
      end
      CMD_READ: begin
        unique case (wadr)
          WADR_DIR:   rd_byte = get_byte(dir_q, hi);
          WADR_INTEN: rd_byte = get_byte(inten_q, hi);
          WADR_DEFV:  rd_byte = get_byte(defv_q, hi);
          WADR_MODE:  rd_byte = get_byte(mode_q, hi);
          WADR_CTRL:  rd_byte = ctrl_q;
          WADR_PULL:  rd_byte = get_byte(pull_q, hi);
          WADR_FLAG:  rd_byte = get_byte(flag_q, hi);
          WADR_CAPT: begin
            rd_byte = get_byte(capt_q, hi);
            flag_d  = flag_q & ~clr_mask;
          end
          WADR_PORT: begin
            rd_byte = get_byte(last_q, hi);
            flag_d  = flag_q & ~clr_mask;
          end
          default:    rd_byte = 8'h00;
        endcase
      end
      CMD_SAMPLE: begin
        // capture a port only on its first flag
        if ((hit[7:0] != 8'h00) && (flag_q[7:0] == 8'h00)) begin
          capt_d[7:0] = s1_q.pin_levels[7:0];
        end
        if ((hit[15:8] != 8'h00) && (flag_q[15:8] == 8'h00)) begin
          capt_d[15:8] = s1_q.pin_levels[15:8];
        end
        flag_d = flag_q | hit;
        last_d = s1_q.pin_levels;
      end
      default: ;  // unused command
    endcase
  end

  // Interrupt lines from the updated flags
  always_comb begin
    act_a = |flag_d[7:0];
    act_b = |flag_d[15:8];
    if (ctrl_d[CTRL_MIRROR_BIT]) begin
      act_a = act_a || act_b;
      act_b = act_a;
    end
    line_a = ctrl_d[CTRL_INTPOL_BIT] ? act_a : !act_a;
    line_b = ctrl_d[CTRL_INTPOL_BIT] ? act_b : !act_b;
  end

  assign res.read_data     = rd_byte;
  assign res.int_a_line    = line_a;
  assign res.int_b_line    = line_b;
  assign res.drive_level   = latch_d;
  assign res.drive_enable  = ~dir_d;
  assign res.pullup_enable = pull_d;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // State registers, updated when the stage-1 item moves to the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_RESET;
      pull_q  <= '0;
      latch_q <= '0;
      inten_q <= '0;
      defv_q  <= '0;
      mode_q  <= '0;
      flag_q  <= '0;
      capt_q  <= '0;
      ctrl_q  <= '0;
      last_q  <= '0;
    end else if (fire) begin
      dir_q   <= dir_d;
      pull_q  <= pull_d;
      latch_q <= latch_d;
      inten_q <= inten_d;
      defv_q  <= defv_d;
      mode_q  <= mode_d;
      flag_q  <= flag_d;
      capt_q  <= capt_d;
      ctrl_q  <= ctrl_d;
      last_q  <= last_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  logic fire_sample;
  logic fire_clr_rd;
  assign fire_sample = fire && (s1_q.command == CMD_SAMPLE);
  assign fire_clr_rd = fire && (s1_q.command == CMD_READ) &&
                       ((wadr == WADR_CAPT) || (wadr == WADR_PORT));

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_flags_set_by_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_sample |=> ((flag_q & ~$past(flag_q)) == 16'h0000))
    else $error("interrupt flag set without a pin sample");

  a_levels_by_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_sample |=> $stable(last_q))
    else $error("pin levels changed without a pin sample");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_clr_rd && !hi) |=> (flag_q[7:0] == 8'h00))
    else $error("port A flags not cleared by read");

endmodule

`default_nettype wire
